// ===== rtl/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared constants, register indexes and saturation helpers for the
// slew-clamped PI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 16;
   localparam int unsigned DATA_W            = 32;
   localparam int unsigned STEP_W            = 31;
   localparam int unsigned CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEP   = 2'd2;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

   // Saturate a 33-bit signed value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat_s33(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? S32_MIN : S32_MAX;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pic_prod_sat.sv =====
// ----------------------------------------------------------------------------
// pic_prod_sat
// Floor-shifts a full fixed-point product down by the fraction bits and
// saturates the result to signed 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_prod_sat
   import pic_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic signed [2*DATA_W-1:0] prod,
   output logic signed [DATA_W-1:0]        term
);

   logic signed [2*DATA_W-1:0] shifted;
   logic                       ovf_pos;
   logic                       ovf_neg;

   // Arithmetic shift is a floor shift.
   assign shifted = prod >>> FRAC_BITS;
   assign ovf_pos = !shifted[2*DATA_W-1] && (|shifted[2*DATA_W-2:DATA_W-1]);
   assign ovf_neg = shifted[2*DATA_W-1] && !(&shifted[2*DATA_W-2:DATA_W-1]);

   always_comb begin
      priority if (ovf_pos) begin
         term = S32_MAX;
      end else if (ovf_neg) begin
         term = S32_MIN;
      end else begin
         term = shifted[DATA_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pi_controller_slew_clamped_feedback_core.sv =====
// ----------------------------------------------------------------------------
// pi_controller_slew_clamped_feedback_core
// Fixed-point PI controller with slew-limited feedback and conditional
// integration anti-windup, duty clamped to 0..1.0.
// ----------------------------------------------------------------------------
// Five-stage pipeline: input register, feedback slew clamp, error and
// integrator, the two gain multiplies, then term saturation, sum and duty
// clamp into the result register. One beat can enter every cycle unless
// rsp_stall has backed up the pipeline to stage 0; the feedback and integral
// state each close their loop within a single stage, so back-to-back beats
// see the state left by the beat before. Each stage holds while the stage
// after it is full and stalled. Gains and step size must only be written
// while the pipeline is empty.
`default_nettype none

module pi_controller_slew_clamped_feedback_core
   import pic_pkg::*;
#(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [DATA_W-1:0]           csr_wdata,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [DATA_W-1:0]    req_target,
   input  wire logic signed [DATA_W-1:0]    req_measured_raw,
   input  wire logic signed [DATA_W-1:0]    req_feedforward,
   input  wire logic                        req_hold_integral,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [FRAC_BITS:0]               rsp_duty
);

   localparam int unsigned DUTY_W = FRAC_BITS + 1;
   localparam int unsigned SUM_W  = DATA_W + 2;
   localparam logic [STEP_W-1:0]      STEP_RESET = STEP_W'(1) << (FRAC_BITS - 2);
   localparam logic signed [SUM_W-1:0] DUTY_ONE  = SUM_W'(1) << FRAC_BITS;

   // configuration registers
   logic signed [DATA_W-1:0] prop_gain_ff;
   logic signed [DATA_W-1:0] integ_gain_ff;
   logic [STEP_W-1:0]        max_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         max_step_ff   <= STEP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            CSR_MAX_STEP:   max_step_ff   <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and ready chain
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign req_stall = !rdy0;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // stage 0: input register
   logic signed [DATA_W-1:0] s0_target_ff, s0_raw_ff, s0_ff_ff;
   logic                     s0_hold_ff;

   always_ff @(posedge clock) begin
      if (rdy0 && req_valid) begin
         s0_target_ff <= req_target;
         s0_raw_ff    <= req_measured_raw;
         s0_ff_ff     <= req_feedforward;
         s0_hold_ff   <= req_hold_integral;
      end
   end

   // stage 1: slew clamp of feedback
   logic signed [DATA_W-1:0] last_fb_ff;
   logic                     have_last_ff;
   logic signed [DATA_W:0]   lo_wide, hi_wide;
   logic signed [DATA_W-1:0] lo_sat, hi_sat;
   logic signed [DATA_W-1:0] fb_in;
   logic                     adv1;

   assign lo_wide  = {last_fb_ff[DATA_W-1], last_fb_ff} - {2'b00, max_step_ff};
   assign hi_wide  = {last_fb_ff[DATA_W-1], last_fb_ff} + {2'b00, max_step_ff};
   assign lo_sat   = sat_s33(lo_wide);
   assign hi_sat   = sat_s33(hi_wide);
   assign adv1     = v0_ff && rdy1;

   always_comb begin
      priority if (!have_last_ff) begin
         fb_in = s0_raw_ff;
      end else if (s0_raw_ff < lo_sat) begin
         fb_in = lo_sat;
      end else if (s0_raw_ff > hi_sat) begin
         fb_in = hi_sat;
      end else begin
         fb_in = s0_raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_fb_ff   <= '0;
         have_last_ff <= 1'b0;
      end else if (adv1) begin
         last_fb_ff   <= fb_in;
         have_last_ff <= 1'b1;
      end
   end

   logic signed [DATA_W-1:0] s1_fb_ff, s1_target_ff, s1_ff_ff;
   logic                     s1_hold_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_fb_ff     <= fb_in;
         s1_target_ff <= s0_target_ff;
         s1_ff_ff     <= s0_ff_ff;
         s1_hold_ff   <= s0_hold_ff;
      end
   end

   // stage 2: error and integrator
   logic signed [DATA_W-1:0] integ_ff;
   logic signed [DATA_W-1:0] err_in, integ_in;
   logic                     adv2;

   assign err_in = sat_s33({s1_target_ff[DATA_W-1], s1_target_ff}
                           - {s1_fb_ff[DATA_W-1], s1_fb_ff});
   assign integ_in = s1_hold_ff ? integ_ff
                   : sat_s33({integ_ff[DATA_W-1], integ_ff} + {err_in[DATA_W-1], err_in});
   assign adv2 = v1_ff && rdy2;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (adv2) begin
         integ_ff <= integ_in;
      end
   end

   logic signed [DATA_W-1:0] s2_err_ff, s2_integ_ff, s2_ff_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_err_ff   <= err_in;
         s2_integ_ff <= integ_in;
         s2_ff_ff    <= s1_ff_ff;
      end
   end

   // stage 3: gain multiplies
   logic signed [2*DATA_W-1:0] s3_pprod_ff, s3_iprod_ff;
   logic signed [DATA_W-1:0]   s3_ff_ff;

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         s3_pprod_ff <= (2*DATA_W)'(prop_gain_ff) * (2*DATA_W)'(s2_err_ff);
         s3_iprod_ff <= (2*DATA_W)'(integ_gain_ff) * (2*DATA_W)'(s2_integ_ff);
         s3_ff_ff    <= s2_ff_ff;
      end
   end

   // stage 4: saturate terms, sum and clamp duty
   logic signed [DATA_W-1:0] p_term, i_term;
   logic signed [SUM_W-1:0]  sum;
   logic [DUTY_W-1:0]        duty_in;
   logic [DUTY_W-1:0]        duty_ff;

   pic_prod_sat #(.FRAC_BITS(FRAC_BITS)) u_prop_sat (
      .prod (s3_pprod_ff),
      .term (p_term)
   );

   pic_prod_sat #(.FRAC_BITS(FRAC_BITS)) u_integ_sat (
      .prod (s3_iprod_ff),
      .term (i_term)
   );

   assign sum = {{2{s3_ff_ff[DATA_W-1]}}, s3_ff_ff}
              + {{2{p_term[DATA_W-1]}}, p_term}
              + {{2{i_term[DATA_W-1]}}, i_term};

   always_comb begin
      priority if (sum[SUM_W-1]) begin
         duty_in = '0;
      end else if (sum > DUTY_ONE) begin
         duty_in = DUTY_ONE[DUTY_W-1:0];
      end else begin
         duty_in = sum[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && rdy4) begin
         duty_ff <= duty_in;
      end
   end

   assign rsp_duty = duty_ff;

endmodule

`default_nettype wire
